// ----- rtl/kcl_pkg.sv -----
// shared types, codes and reset values for the keypad combination lock
package kcl_pkg;

  typedef enum logic [2:0] {
    MODE_STANDBY = 3'd0,
    MODE_AWAIT   = 3'd1,
    MODE_ENTRY   = 3'd2,
    MODE_MENU    = 3'd3,
    MODE_HOLD    = 3'd4,
    MODE_LOCK    = 3'd5
  } mode_t;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_DIST = 2'd2;

  localparam logic [7:0] KEY_EQ   = 8'h3D;
  localparam logic [7:0] KEY_0    = 8'h30;
  localparam logic [7:0] KEY_9    = 8'h39;
  localparam logic [7:0] KEY_1    = 8'h31;
  localparam logic [7:0] KEY_2    = 8'h32;

  localparam logic [2:0] REG_PASSWORD  = 3'd0;
  localparam logic [2:0] REG_NEAR      = 3'd1;
  localparam logic [2:0] REG_KEY_TMO   = 3'd2;
  localparam logic [2:0] REG_MAX_TRIAL = 3'd3;
  localparam logic [2:0] REG_LOCKOUT   = 3'd4;
  localparam logic [2:0] REG_HOLD      = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] RST_PASSWORD  = 16'd1997;
  localparam logic [9:0]  RST_NEAR      = 10'd15;
  localparam logic [31:0] RST_KEY_TMO   = 32'd35000;
  localparam logic [3:0]  RST_MAX_TRIAL = 4'd3;
  localparam logic [31:0] RST_LOCKOUT   = 32'd120000000;
  localparam logic [31:0] RST_HOLD      = 32'd50000000;

  typedef struct packed {
    logic [15:0] password;
    logic [9:0]  near_threshold_cm;
    logic [31:0] key_timeout_ticks;
    logic [3:0]  max_trials;
    logic [31:0] lockout_ticks;
    logic [31:0] relay_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_char;
    logic [9:0] distance_cm;
  } evt_t;

  typedef struct packed {
    logic       granted;
    logic       wrong_code;
    logic       digit_echo;
    logic       light_on;
    logic       relay_on;
    mode_t      mode;
  } res_t;

endpackage

// ----- rtl/kcl_cfg.sv -----
// configuration register file of the keypad combination lock
module kcl_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output kcl_pkg::cfg_t                 cfg
);

  kcl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.password          <= kcl_pkg::RST_PASSWORD;
      cfg_r.near_threshold_cm <= kcl_pkg::RST_NEAR;
      cfg_r.key_timeout_ticks <= kcl_pkg::RST_KEY_TMO;
      cfg_r.max_trials        <= kcl_pkg::RST_MAX_TRIAL;
      cfg_r.lockout_ticks     <= kcl_pkg::RST_LOCKOUT;
      cfg_r.relay_hold_ticks  <= kcl_pkg::RST_HOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        kcl_pkg::REG_PASSWORD:  cfg_r.password          <= cfg_wdata[15:0];
        kcl_pkg::REG_NEAR:      cfg_r.near_threshold_cm <= cfg_wdata[9:0];
        kcl_pkg::REG_KEY_TMO:   cfg_r.key_timeout_ticks <= cfg_wdata[31:0];
        kcl_pkg::REG_MAX_TRIAL: cfg_r.max_trials        <= cfg_wdata[3:0];
        kcl_pkg::REG_LOCKOUT:   cfg_r.lockout_ticks     <= cfg_wdata[31:0];
        kcl_pkg::REG_HOLD:      cfg_r.relay_hold_ticks  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/kcl_core.sv -----
// lock state machine: mode, code entry, trial count, idle counter and outputs
module kcl_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  kcl_pkg::evt_t evt,
  input  kcl_pkg::cfg_t cfg,
  output kcl_pkg::res_t res
);

  localparam int LW = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;
  localparam logic [COUNTER_WIDTH-1:0] CMAX = {COUNTER_WIDTH{1'b1}};

  kcl_pkg::mode_t             mode_r, mode_nxt;
  logic [15:0]                entered_r, entered_nxt;
  logic [COUNTER_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [3:0]                 wrong_r, wrong_nxt;
  logic                       retry_r, retry_nxt;
  logic                       relay_r, relay_nxt;
  logic                       light_r, light_nxt;

  logic [COUNTER_WIDTH-1:0]   cnt_inc;
  logic [31:0]                lim_sel;
  logic [LW-1:0]              lim_ext, lim_clamp, cnt_ext, cmax_ext;
  logic                       expired;
  logic                       is_tick, is_key, is_digit, pw_match, trials_out;
  logic [15:0]                digit_val;
  logic                       echo, wrong, ok;

  // idle counter saturates; expiry limit is clamped to the counter maximum
  assign cnt_inc   = (cnt_r == CMAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext   = LW'(cnt_inc);
  assign cmax_ext  = LW'(CMAX);
  assign lim_ext   = LW'(lim_sel);
  assign lim_clamp = (lim_ext > cmax_ext) ? cmax_ext : lim_ext;
  assign expired   = (cnt_ext >= lim_clamp);

  assign is_tick    = (evt.command == kcl_pkg::CMD_TICK);
  assign is_key     = (evt.command == kcl_pkg::CMD_KEY);
  assign is_digit   = (evt.key_char >= kcl_pkg::KEY_0) && (evt.key_char <= kcl_pkg::KEY_9);
  assign digit_val  = {8'd0, evt.key_char - kcl_pkg::KEY_0};
  assign pw_match   = (entered_r == cfg.password);
  assign trials_out = ({1'b0, wrong_r} + 5'd1) >= {1'b0, cfg.max_trials};

  always_comb begin
    case (mode_r)
      kcl_pkg::MODE_HOLD: lim_sel = cfg.relay_hold_ticks;
      kcl_pkg::MODE_LOCK: lim_sel = cfg.lockout_ticks;
      default:            lim_sel = cfg.key_timeout_ticks;
    endcase
  end

  always_comb begin
    logic do_submit;
    logic do_standby;
    mode_nxt    = mode_r;
    entered_nxt = entered_r;
    cnt_nxt     = cnt_r;
    wrong_nxt   = wrong_r;
    retry_nxt   = retry_r;
    relay_nxt   = relay_r;
    light_nxt   = light_r;
    echo        = 1'b0;
    wrong       = 1'b0;
    ok          = 1'b0;
    do_submit   = 1'b0;
    do_standby  = 1'b0;

    case (mode_r)
      kcl_pkg::MODE_STANDBY: begin
        if (evt.command == kcl_pkg::CMD_DIST &&
            evt.distance_cm <= cfg.near_threshold_cm) begin
          mode_nxt    = kcl_pkg::MODE_AWAIT;
          entered_nxt = 16'd0;
          cnt_nxt     = '0;
        end
      end
      kcl_pkg::MODE_AWAIT: begin
        if (is_key) begin
          mode_nxt    = kcl_pkg::MODE_ENTRY;
          entered_nxt = 16'd0;
          cnt_nxt     = '0;
        end else if (is_tick) begin
          cnt_nxt    = cnt_inc;
          do_standby = expired;
        end
      end
      kcl_pkg::MODE_ENTRY: begin
        if (is_key) begin
          if (evt.key_char == kcl_pkg::KEY_EQ) begin
            do_submit = 1'b1;
          end else if (is_digit) begin
            // times ten as shift-and-add, wraps at 16 bits
            entered_nxt = (entered_r << 3) + (entered_r << 1) + digit_val;
            echo        = 1'b1;
          end
        end else if (is_tick) begin
          cnt_nxt = cnt_inc;
          if (expired) begin
            do_submit  = retry_r;
            do_standby = !retry_r;
          end
        end
      end
      kcl_pkg::MODE_MENU: begin
        if (is_key && (evt.key_char == kcl_pkg::KEY_1 || evt.key_char == kcl_pkg::KEY_2)) begin
          light_nxt = (evt.key_char == kcl_pkg::KEY_1);
          mode_nxt  = kcl_pkg::MODE_HOLD;
          cnt_nxt   = '0;
        end
      end
      kcl_pkg::MODE_HOLD: begin
        if (is_tick) begin
          cnt_nxt = cnt_inc;
          if (expired) begin
            relay_nxt  = 1'b0;
            do_standby = 1'b1;
          end
        end
      end
      kcl_pkg::MODE_LOCK: begin
        if (is_tick) begin
          cnt_nxt    = cnt_inc;
          do_standby = expired;
        end
      end
      default: begin
        do_standby = 1'b1;
      end
    endcase

    if (do_submit) begin
      cnt_nxt   = '0;
      retry_nxt = 1'b0;
      if (pw_match) begin
        ok        = 1'b1;
        wrong_nxt = 4'd0;
        relay_nxt = 1'b1;
        mode_nxt  = kcl_pkg::MODE_MENU;
      end else if (trials_out) begin
        mode_nxt    = kcl_pkg::MODE_LOCK;
        wrong_nxt   = 4'd0;
        entered_nxt = 16'd0;
      end else begin
        wrong       = 1'b1;
        wrong_nxt   = wrong_r + 4'd1;
        entered_nxt = 16'd0;
        retry_nxt   = 1'b1;
        mode_nxt    = kcl_pkg::MODE_ENTRY;
      end
    end

    if (do_standby) begin
      mode_nxt    = kcl_pkg::MODE_STANDBY;
      entered_nxt = 16'd0;
      retry_nxt   = 1'b0;
      cnt_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= kcl_pkg::MODE_STANDBY;
      entered_r <= 16'd0;
      cnt_r     <= '0;
      wrong_r   <= 4'd0;
      retry_r   <= 1'b0;
      relay_r   <= 1'b0;
      light_r   <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      entered_r <= entered_nxt;
      cnt_r     <= cnt_nxt;
      wrong_r   <= wrong_nxt;
      retry_r   <= retry_nxt;
      relay_r   <= relay_nxt;
      light_r   <= light_nxt;
    end
  end

  assign res.mode       = mode_nxt;
  assign res.relay_on   = relay_nxt;
  assign res.light_on   = light_nxt;
  assign res.digit_echo = echo;
  assign res.wrong_code = wrong;
  assign res.granted    = ok;

endmodule

// ----- rtl/keypad_combination_lock.sv -----
// keypad combination lock: event stream in, one status word out per event
// an accepted event waits in the input register, then its result word in the result register
// throughput: one word per cycle while out_tready stays high; each event is resolved in a single pass
// in_tready stays high while the input register is empty or the result register is empty or being taken
// reset (rst_n low, synchronous): standby mode, counters cleared, relay and light off,
// configuration registers back to their defaults, both stages empty
module keypad_combination_lock #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // key_char[7:0], distance_cm[17:8], pad
  input  logic [1:0]                     in_tuser,   // command[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // mode[2:0], relay_on, light_on,
                                                     // digit_echo, wrong_code, granted
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  kcl_pkg::cfg_t cfg;
  kcl_pkg::evt_t evt_r;
  kcl_pkg::res_t res;
  logic          s1_valid_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          advance;
  logic          step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      evt_r.command     <= in_tuser;
      evt_r.key_char    <= in_tdata[7:0];
      evt_r.distance_cm <= in_tdata[17:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  kcl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kcl_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .evt   (evt_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/kcl_checker.sv -----
// port-level assertions for the keypad combination lock, bound to the top level
module kcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // relay is driven exactly in menu and relay hold
  a_relay_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] == (out_tdata[2:0] == kcl_pkg::MODE_MENU ||
                                     out_tdata[2:0] == kcl_pkg::MODE_HOLD)))
    else $error("relay state does not match mode");

  // at most one event pulse per word
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[7:5]))
    else $error("more than one pulse in a word");

  // pulses land in the mode they lead to
  a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5] || out_tdata[6] || out_tdata[7]) |->
      (out_tdata[7] ? (out_tdata[2:0] == kcl_pkg::MODE_MENU)
                    : (out_tdata[2:0] == kcl_pkg::MODE_ENTRY)))
    else $error("pulse with unexpected mode");

endmodule

bind keypad_combination_lock kcl_checker u_kcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
